// ===== src/ikvt_pkg.sv =====
// ----------------------------------------------------------------------------
// ikvt_pkg
// Shared types, codes and arithmetic helpers of the integer key/value table.
// ----------------------------------------------------------------------------
package ikvt_pkg;

    localparam int REQ_W           = 2;
    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 64;
    localparam int SIZE_W          = 20;
    localparam int TOTAL_W         = 32;
    localparam int TABLE_DEPTH_DEF = 64;

    typedef logic [REQ_W-1:0] req_code_t;

    localparam req_code_t REQ_LOOKUP = 2'd0;
    localparam req_code_t REQ_SET    = 2'd1;
    localparam req_code_t REQ_APPEND = 2'd2;
    localparam req_code_t REQ_CLEAR  = 2'd3;

    typedef logic status_t;

    localparam status_t STATUS_OK   = 1'b0;
    localparam status_t STATUS_FULL = 1'b1;

    typedef struct packed {
        req_code_t                req_type;
        logic signed [KEY_W-1:0]  key;
        logic [VALUE_W-1:0]       new_value;
        logic [SIZE_W-1:0]        entry_size;
    } req_item_t;

    typedef struct packed {
        logic                     found;
        logic [VALUE_W-1:0]       found_value;
        logic [TOTAL_W-1:0]       total_size;
        status_t                  status;
    } rsp_item_t;

    // one table entry as held in the store
    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic [VALUE_W-1:0]       value;
        logic [SIZE_W-1:0]        size;
    } entry_t;

    function automatic logic [TOTAL_W-1:0] sat_add(
        input logic [TOTAL_W-1:0] total,
        input logic [SIZE_W-1:0]  size
    );
        logic [TOTAL_W:0] sum;
        sum = {1'b0, total} + (TOTAL_W+1)'(size);
        return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    endfunction

    // subtract with a floor at zero
    function automatic logic [TOTAL_W-1:0] floor_sub(
        input logic [TOTAL_W-1:0] total,
        input logic [SIZE_W-1:0]  size
    );
        logic [TOTAL_W-1:0] size_ext;
        size_ext = TOTAL_W'(size);
        return (total >= size_ext) ? (total - size_ext) : '0;
    endfunction

endpackage

// ===== src/ikvt_store.sv =====
// ----------------------------------------------------------------------------
// ikvt_store
// Entry memory of the table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ikvt_store
    import ikvt_pkg::*;
#(
    parameter int DEPTH  = TABLE_DEPTH_DEF,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/int_key_value_table.sv =====
// ----------------------------------------------------------------------------
// int_key_value_table
// Integer-keyed table of value words and size counts, searched linearly.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_item and are taken when req_stall is low;
// each request gives exactly one response item on rsp_valid/rsp_item, which
// the receiver takes when rsp_stall is low.
// One request is worked on at a time. Lookup and set walk the entries from
// oldest to newest, one key compare per cycle out of the entry memory's
// single read port, and stop at the first match. A set then rewrites the
// matching entry and updates the size total in ST_ADD, or appends on a miss.
// Append passes through ST_APPEND to ST_DONE; clear goes straight to ST_DONE.
// The response sits in an output register: a new request is taken while
// an earlier response is stalled, and the block only waits at its end if
// the output register is still full.
// Reset empties the table and zeroes the size total; the entry memory
// itself is not cleared, only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module int_key_value_table
    import ikvt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_item
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD,
        ST_APPEND,
        ST_DONE
    } state_t;

    state_t             state_reg,     state_next;
    req_item_t          req_reg,       req_next;
    logic [IDX_W-1:0]   cmp_idx_reg,   cmp_idx_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [TOTAL_W-1:0] total_reg,     total_next;
    logic               found_reg,     found_next;
    logic [VALUE_W-1:0] fvalue_reg,    fvalue_next;
    status_t            status_reg,    status_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_item_reg,  rsp_item_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic hit;
    logic last;
    logic full;

    ikvt_store #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign hit  = (rd_data.key == $unsigned(req_reg.key));
    assign last = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg);
    assign full = (count_reg == CNT_W'(TABLE_DEPTH));

    assign wr_data = '{key: $unsigned(req_reg.key), value: req_reg.new_value,
                       size: req_reg.entry_size};

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        cmp_idx_next   = cmp_idx_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        found_next     = found_reg;
        fvalue_next    = fvalue_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;

        rd_en   = 1'b0;
        rd_addr = cmp_idx_reg + IDX_W'(1);
        wr_en   = 1'b0;
        wr_addr = cmp_idx_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next     = req_item;
                    found_next   = 1'b0;
                    fvalue_next  = '0;
                    status_next  = STATUS_OK;
                    cmp_idx_next = '0;
                    unique case (req_item.req_type) inside
                        REQ_LOOKUP, REQ_SET:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = (req_item.req_type == REQ_LOOKUP) ?
                                             ST_DONE : ST_APPEND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_APPEND:
                        begin
                            state_next = ST_APPEND;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // rd_data holds the entry at cmp_idx_reg; the next one is prefetched
            ST_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    if (req_reg.req_type == REQ_LOOKUP)
                    begin
                        fvalue_next = rd_data.value;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = cmp_idx_reg;
                        total_next = floor_sub(total_reg, rd_data.size);
                        state_next = ST_ADD;
                    end
                end
                else if (last)
                begin
                    state_next = (req_reg.req_type == REQ_LOOKUP) ? ST_DONE : ST_APPEND;
                end
                else
                begin
                    rd_en        = 1'b1;
                    cmp_idx_next = cmp_idx_reg + IDX_W'(1);
                end
            end

            ST_ADD:
            begin
                total_next = sat_add(total_reg, req_reg.entry_size);
                state_next = ST_DONE;
            end

            ST_APPEND:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    total_next = sat_add(total_reg, req_reg.entry_size);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_item_next  = '{found: found_reg, found_value: fvalue_reg,
                                       total_size: total_reg, status: status_reg};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            cmp_idx_reg   <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            found_reg     <= 1'b0;
            fvalue_reg    <= '0;
            status_reg    <= STATUS_OK;
            rsp_valid_reg <= 1'b0;
            rsp_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            cmp_idx_reg   <= cmp_idx_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            found_reg     <= found_next;
            fvalue_reg    <= fvalue_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_item_reg  <= rsp_item_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

// ===== src/ikvt_chk.sv =====
// ----------------------------------------------------------------------------
// ikvt_chk
// Port-level checks of the integer key/value table, bound to the top level.
// ----------------------------------------------------------------------------
module ikvt_chk
    import ikvt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp_item
);

    // every request leaves the idle state, so the block stalls right after accept
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall
    ) else $error("request side not stalled after an item was accepted");

    // a refused insert never reports a match
    a_full_not_found: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.status == STATUS_FULL) |-> !rsp_item.found
    ) else $error("full status given together with found");

    // a value word is only returned on a hit
    a_value_needs_hit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.found_value != '0) |-> rsp_item.found
    ) else $error("nonzero found_value without found");

    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item))
    ) else $error("stalled response item changed or dropped");

endmodule

bind int_key_value_table ikvt_chk u_ikvt_chk (.*);
